[rtl/core/ltpe_pkg.sv]
// ----------------------------------------------------------------------------
// ltpe_pkg
// Shared types and constants for the line-table program encoder: field
// widths, opcodes, line-program byte codes and the item control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ltpe_pkg;

    // fixed field widths of the channels
    localparam int OPCODE_W  = 2;
    localparam int OFFSET_W  = 32;
    localparam int LINENUM_W = 24;
    localparam int BYTE_W    = 8;

    // default state widths
    localparam int ADDR_BITS_DEF = 32;
    localparam int LINE_BITS_DEF = 24;

    // address deltas are encoded as 64-bit wrapped values
    localparam int ULEB_W = 64;

    // byte counter for the fixed sequences
    localparam int CNT_W          = 4;
    localparam int START_LEN      = 11;
    localparam int START_ADDR_IDX = 3;
    localparam int END_LEN        = 3;

    // line-program byte codes
    localparam logic [BYTE_W-1:0] LNE_ESCAPE      = 8'h00;
    localparam logic [BYTE_W-1:0] LNE_SET_ADDR_LN = 8'h09;
    localparam logic [BYTE_W-1:0] LNE_SET_ADDRESS = 8'h02;
    localparam logic [BYTE_W-1:0] LNE_END_LEN     = 8'h01;
    localparam logic [BYTE_W-1:0] LNE_END_SEQ     = 8'h01;
    localparam logic [BYTE_W-1:0] LNS_COPY        = 8'h01;
    localparam logic [BYTE_W-1:0] LNS_ADVANCE_PC  = 8'h02;
    localparam logic [BYTE_W-1:0] LNS_ADVANCE_LN  = 8'h03;
    localparam logic [BYTE_W-1:0] ZERO_BYTE       = 8'h00;

    // item opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_START = 2'd0,
        OP_ROW   = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // control part of a pre-computed item
    typedef struct packed {
        opcode_t op;
        logic    line_chg;
        logic    pc_chg;
    } item_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/ltpe_delta.sv]
// ----------------------------------------------------------------------------
// ltpe_delta
// Input register stage: takes a transaction, works out the line and address
// deltas against the held state, updates the state and holds the item.
// ----------------------------------------------------------------------------
`default_nettype none

module ltpe_delta #(
    parameter int ADDR_BITS = ltpe_pkg::ADDR_BITS_DEF,
    parameter int LINE_BITS = ltpe_pkg::LINE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ltpe_pkg::OPCODE_W-1:0]     s_opcode,
    input  logic [ltpe_pkg::OFFSET_W-1:0]     s_code_offset,
    input  logic [ltpe_pkg::LINENUM_W-1:0]    s_line_number,
    output logic                              item_valid,
    input  logic                              item_ready,
    output ltpe_pkg::item_ctrl_t              item_ctrl,
    output logic signed [LINE_BITS:0]         item_line_delta,
    output logic [ltpe_pkg::ULEB_W-1:0]       item_pc_delta
);
    import ltpe_pkg::*;

    logic [ADDR_BITS-1:0]      cur_addr_reg, cur_addr_next;
    logic [LINE_BITS-1:0]      cur_line_reg, cur_line_next;
    logic                      item_valid_reg, item_valid_next;
    item_ctrl_t                item_ctrl_reg;
    logic signed [LINE_BITS:0] item_line_delta_reg;
    logic [ULEB_W-1:0]         item_pc_delta_reg;

    opcode_t                   op_in;
    logic [ADDR_BITS-1:0]      addr_in;
    logic [LINE_BITS-1:0]      line_in;
    logic signed [LINE_BITS:0] line_diff;
    logic signed [ADDR_BITS:0] addr_diff;
    logic [ULEB_W-1:0]         addr_diff_ext;
    logic                      line_chg;
    logic                      pc_chg;
    logic                      s_fire;

    // field extraction and deltas against the held state
    assign op_in         = opcode_t'(s_opcode);
    assign addr_in       = ADDR_BITS'(s_code_offset);
    assign line_in       = LINE_BITS'(s_line_number);
    assign line_diff     = signed'({1'b0, line_in}) - signed'({1'b0, cur_line_reg});
    assign addr_diff     = signed'({1'b0, addr_in}) - signed'({1'b0, cur_addr_reg});
    assign addr_diff_ext = ULEB_W'(addr_diff);
    assign line_chg      = (line_in != cur_line_reg);
    assign pc_chg        = (addr_in != cur_addr_reg);

    assign s_ready = !item_valid_reg || item_ready;
    assign s_fire  = s_valid && s_ready;

    // state update on each accepted transaction
    always_comb begin
        cur_addr_next = cur_addr_reg;
        cur_line_next = cur_line_reg;
        if (s_fire) begin
            case (op_in)
                OP_START: begin
                    cur_addr_next = addr_in;
                    cur_line_next = LINE_BITS'(1);
                end
                OP_ROW: begin
                    cur_addr_next = addr_in;
                    cur_line_next = line_in;
                end
                OP_END: begin
                    cur_addr_next = addr_in;
                end
                default: begin
                    cur_addr_next = cur_addr_reg;
                end
            endcase
        end
    end

    // item holding register, unused opcode leaves nothing behind
    always_comb begin
        if (s_fire) begin
            item_valid_next = (op_in != OP_NONE);
        end else if (item_ready) begin
            item_valid_next = 1'b0;
        end else begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_addr_reg   <= '0;
            cur_line_reg   <= LINE_BITS'(1);
            item_valid_reg <= 1'b0;
        end else begin
            cur_addr_reg   <= cur_addr_next;
            cur_line_reg   <= cur_line_next;
            item_valid_reg <= item_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_ctrl_reg.op       <= op_in;
            item_ctrl_reg.line_chg <= line_chg;
            item_ctrl_reg.pc_chg   <= pc_chg;
            item_line_delta_reg    <= line_diff;
            item_pc_delta_reg      <= addr_diff_ext;
        end
    end

    assign item_valid      = item_valid_reg;
    assign item_ctrl       = item_ctrl_reg;
    assign item_line_delta = item_line_delta_reg;
    assign item_pc_delta   = item_pc_delta_reg;

`ifndef SYNTHESIS
    // a start transaction resets the current line
    a_start_line: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (op_in == OP_START) |=> cur_line_reg == LINE_BITS'(1))
        else $error("current line not reset by start");

    // a real opcode always leaves an item behind
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (op_in != OP_NONE) |=> item_valid_reg)
        else $error("accepted item lost");

    // a held item keeps its deltas until the emitter takes it
    a_item_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && !item_ready |=>
            item_valid_reg && $stable(item_pc_delta_reg) && $stable(item_line_delta_reg))
        else $error("held item changed before being taken");
`endif

endmodule

`default_nettype wire

[rtl/core/ltpe_emit.sv]
// ----------------------------------------------------------------------------
// ltpe_emit
// Byte sequencer with output register: walks one item's opcode bytes and LEB128
// groups one byte per cycle unless stalled; the last byte loads the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module ltpe_emit #(
    parameter int LINE_BITS = ltpe_pkg::LINE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  ltpe_pkg::item_ctrl_t          item_ctrl,
    input  logic signed [LINE_BITS:0]     item_line_delta,
    input  logic [ltpe_pkg::ULEB_W-1:0]   item_pc_delta,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ltpe_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                          m_reloc_start,
    output logic                          m_last
);
    import ltpe_pkg::*;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_START    = 8'b0000_0010,
        PH_LINE_OP  = 8'b0000_0100,
        PH_LINE_VAL = 8'b0000_1000,
        PH_PC_OP    = 8'b0001_0000,
        PH_PC_VAL   = 8'b0010_0000,
        PH_COPY     = 8'b0100_0000,
        PH_END      = 8'b1000_0000
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [LINE_BITS:0] sleb_reg, sleb_next;
    logic [ULEB_W-1:0]         uleb_reg, uleb_next;
    logic                      row_reg, row_next;
    logic                      pc_chg_reg, pc_chg_next;
    logic                      m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]         m_out_byte_reg;
    logic                      m_reloc_start_reg;
    logic                      m_last_reg;

    logic                      advance;
    logic signed [LINE_BITS:0] sleb_shift;
    logic                      sleb_done;
    logic [ULEB_W-1:0]         uleb_shift;
    logic                      uleb_done;
    logic [BYTE_W-1:0]         byte_val;
    logic                      byte_reloc;
    logic                      byte_last;

    // a byte moves whenever the output register is free or being drained
    assign advance = (phase_reg != PH_IDLE) && (!m_valid_reg || m_ready);

    // leb128 group termination
    assign sleb_shift = sleb_reg >>> 7;
    assign sleb_done  = ((sleb_shift == '0) && !sleb_reg[6]) ||
                        ((sleb_shift == '1) && sleb_reg[6]);
    assign uleb_shift = uleb_reg >> 7;
    assign uleb_done  = (uleb_shift == '0);

    // byte of the current phase
    always_comb begin
        byte_val   = ZERO_BYTE;
        byte_reloc = 1'b0;
        byte_last  = 1'b0;
        case (phase_reg)
            PH_START: begin
                case (cnt_reg)
                    CNT_W'(0): byte_val = LNE_ESCAPE;
                    CNT_W'(1): byte_val = LNE_SET_ADDR_LN;
                    CNT_W'(2): byte_val = LNE_SET_ADDRESS;
                    default:   byte_val = ZERO_BYTE;
                endcase
                byte_reloc = (cnt_reg == CNT_W'(START_ADDR_IDX));
                byte_last  = (cnt_reg == CNT_W'(START_LEN - 1));
            end
            PH_LINE_OP: byte_val = LNS_ADVANCE_LN;
            PH_LINE_VAL: byte_val = {!sleb_done, sleb_reg[6:0]};
            PH_PC_OP: byte_val = LNS_ADVANCE_PC;
            PH_PC_VAL: byte_val = {!uleb_done, uleb_reg[6:0]};
            PH_COPY: begin
                byte_val  = LNS_COPY;
                byte_last = 1'b1;
            end
            PH_END: begin
                case (cnt_reg)
                    CNT_W'(0): byte_val = LNE_ESCAPE;
                    CNT_W'(1): byte_val = LNE_END_LEN;
                    default:   byte_val = LNE_END_SEQ;
                endcase
                byte_last = (cnt_reg == CNT_W'(END_LEN - 1));
            end
            default: byte_val = ZERO_BYTE;
        endcase
    end

    assign item_ready = (phase_reg == PH_IDLE) || (advance && byte_last);

    // phase sequencing and next-item load
    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        sleb_next   = sleb_reg;
        uleb_next   = uleb_reg;
        row_next    = row_reg;
        pc_chg_next = pc_chg_reg;

        if (advance) begin
            case (phase_reg)
                PH_START: cnt_next = cnt_reg + CNT_W'(1);
                PH_LINE_OP: phase_next = PH_LINE_VAL;
                PH_LINE_VAL: begin
                    sleb_next = sleb_shift;
                    if (sleb_done) begin
                        phase_next = pc_chg_reg ? PH_PC_OP : PH_COPY;
                    end
                end
                PH_PC_OP: phase_next = PH_PC_VAL;
                PH_PC_VAL: begin
                    uleb_next = uleb_shift;
                    if (uleb_done) begin
                        phase_next = row_reg ? PH_COPY : PH_END;
                        cnt_next   = '0;
                    end
                end
                PH_END: cnt_next = cnt_reg + CNT_W'(1);
                default: phase_next = phase_reg;
            endcase
        end

        if (item_ready) begin
            if (item_valid) begin
                sleb_next   = item_line_delta;
                uleb_next   = item_pc_delta;
                cnt_next    = '0;
                row_next    = (item_ctrl.op == OP_ROW);
                pc_chg_next = item_ctrl.pc_chg;
                case (item_ctrl.op)
                    OP_START: phase_next = PH_START;
                    OP_ROW: begin
                        if (item_ctrl.line_chg) begin
                            phase_next = PH_LINE_OP;
                        end else if (item_ctrl.pc_chg) begin
                            phase_next = PH_PC_OP;
                        end else begin
                            phase_next = PH_COPY;
                        end
                    end
                    OP_END: phase_next = item_ctrl.pc_chg ? PH_PC_OP : PH_END;
                    default: phase_next = PH_IDLE;
                endcase
            end else begin
                phase_next = PH_IDLE;
            end
        end
    end

    // output register valid
    always_comb begin
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working values and output payload
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        sleb_reg   <= sleb_next;
        uleb_reg   <= uleb_next;
        row_reg    <= row_next;
        pc_chg_reg <= pc_chg_next;
        if (advance) begin
            m_out_byte_reg    <= byte_val;
            m_reloc_start_reg <= byte_reloc;
            m_last_reg        <= byte_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_reloc_start = m_reloc_start_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTHESIS
    // the relocated address starts with a zero byte and never ends an item
    a_reloc_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_reloc_start_reg |-> (m_out_byte_reg == ZERO_BYTE) && !m_last_reg)
        else $error("relocation mark on a wrong byte");

    // every item closes with copy, the end-of-sequence code or the last address byte
    a_last_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |->
            (m_out_byte_reg == LNS_COPY) || (m_out_byte_reg == ZERO_BYTE))
        else $error("unexpected final byte of a transaction");

    // a loaded item is always worked on
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        item_ready && item_valid |=> phase_reg != PH_IDLE)
        else $error("item taken but sequencer idle");
`endif

endmodule

`default_nettype wire

[rtl/core/line_table_program_encoder_core.sv]
// ----------------------------------------------------------------------------
// line_table_program_encoder_core
// Line-number program encoder: opcode-marked items in, program bytes out.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one transaction per item (opcode, code_offset, line_number).
//   m_ channel: one transaction per program byte; m_last marks the final byte
//   of an item and m_reloc_start the first of the eight address bytes.
//   Opcode 3 is accepted and dropped without any output.
// Latency: an item goes through the held item register and the sequencer
//   phase register into the output register when the sequencer is free.
// Throughput: one byte per cycle while the receiver does not stall; an item
//   produces 11 bytes for start, 1 to 17 for a row, 3 to 14 for end; the byte
//   sequencer with its single output register sets this rate.
// The next item is accepted while the current one is still being sent.
// Reset (aresetn low, synchronous): current address 0, current line 1, both
//   channels empty.
// Receiver stall: the output byte holds, the sequencer pauses, and input is
//   back-pressured once the held item register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module line_table_program_encoder_core #(
    parameter int ADDR_BITS = ltpe_pkg::ADDR_BITS_DEF,
    parameter int LINE_BITS = ltpe_pkg::LINE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ltpe_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [ltpe_pkg::OFFSET_W-1:0]  s_code_offset,
    input  logic [ltpe_pkg::LINENUM_W-1:0] s_line_number,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ltpe_pkg::BYTE_W-1:0]    m_out_byte,
    output logic                           m_reloc_start,
    output logic                           m_last
);
    import ltpe_pkg::*;

    logic                      item_valid;
    logic                      item_ready;
    item_ctrl_t                item_ctrl;
    logic signed [LINE_BITS:0] item_line_delta;
    logic [ULEB_W-1:0]         item_pc_delta;

    // input register and delta computation
    ltpe_delta #(
        .ADDR_BITS (ADDR_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_delta (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_code_offset   (s_code_offset),
        .s_line_number   (s_line_number),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item_ctrl       (item_ctrl),
        .item_line_delta (item_line_delta),
        .item_pc_delta   (item_pc_delta)
    );

    // byte sequencer and output register
    ltpe_emit #(
        .LINE_BITS (LINE_BITS)
    ) u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item_ctrl       (item_ctrl),
        .item_line_delta (item_line_delta),
        .item_pc_delta   (item_pc_delta),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_reloc_start   (m_reloc_start),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for line_table_program_encoder_core. Items go in through
// a queue-fed driver, every accepted item is encoded by a behavioural
// predictor of the line program, and each byte leaving the block is compared
// with the oldest predicted byte. Traffic runs through phases of sender and
// receiver idling, plus a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ltpe_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 7;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 30;
    localparam int MAX_REPORTS      = 40;
    localparam int ADDR_BYTES       = START_LEN - START_ADDR_IDX;

    typedef struct packed {
        opcode_t               op;
        logic [OFFSET_W-1:0]   offset;
        logic [LINENUM_W-1:0]  line_no;
    } line_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              reloc;
        logic              last;
    } prog_byte_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // block ports
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [OPCODE_W-1:0]  s_opcode      = '0;
    logic [OFFSET_W-1:0]  s_code_offset = '0;
    logic [LINENUM_W-1:0] s_line_number = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [BYTE_W-1:0]    m_out_byte;
    logic                 m_reloc_start;
    logic                 m_last;

    line_table_program_encoder_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_code_offset (s_code_offset),
        .s_line_number (s_line_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_reloc_start (m_reloc_start),
        .m_last        (m_last)
    );

    // stimulus and prediction stores
    line_item_t  pending_items[$];
    prog_byte_t  expected_prog_bytes[$];
    prog_byte_t  item_bytes[$];
    line_item_t  next_item;
    prog_byte_t  want_byte;

    // predictor state
    logic [OFFSET_W-1:0]  enc_address = '0;
    logic [LINENUM_W-1:0] enc_line    = 1;

    // idling control
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_active    = 1'b0;
    logic in_taken       = 1'b0;
    event long_hold_go;

    // bookkeeping
    int cycle_count   = 0;
    int mismatches    = 0;
    int bytes_checked = 0;
    int n_start       = 0;
    int n_row         = 0;
    int n_end         = 0;
    int n_ignored     = 0;
    int longest_item  = 0;
    int items_queued  = 0;

    // ------------------------------------------------------------------
    // line program predictor
    // ------------------------------------------------------------------
    function automatic void push_prog_byte(logic [BYTE_W-1:0] value, logic reloc);
        prog_byte_t pb;
        pb.data  = value;
        pb.reloc = reloc;
        pb.last  = 1'b0;
        item_bytes.push_back(pb);
    endfunction

    function automatic void push_uleb(logic [ULEB_W-1:0] value);
        logic [ULEB_W-1:0] v;
        logic [BYTE_W-1:0] b;
        v = value;
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != '0) b[7] = 1'b1;
            push_prog_byte(b, 1'b0);
        end while (v != '0);
    endfunction

    function automatic void push_sleb(logic [ULEB_W-1:0] value);
        logic [ULEB_W-1:0] v;
        logic [BYTE_W-1:0] b;
        bit                more;
        v    = value;
        more = 1'b1;
        while (more) begin
            b = {1'b0, v[6:0]};
            v = {{7{v[ULEB_W-1]}}, v[ULEB_W-1:7]};
            if ((v == '0 && !b[6]) || (v == '1 && b[6]))
                more = 1'b0;
            else
                b[7] = 1'b1;
            push_prog_byte(b, 1'b0);
        end
    endfunction

    // address advance with a 64-bit wrapped delta, only when the address moves
    function automatic void push_pc_advance(logic [OFFSET_W-1:0] target);
        if (target != enc_address) begin
            push_prog_byte(LNS_ADVANCE_PC, 1'b0);
            push_uleb({{(ULEB_W-OFFSET_W){1'b0}}, target}
                      - {{(ULEB_W-OFFSET_W){1'b0}}, enc_address});
        end
        enc_address = target;
    endfunction

    function automatic void encode_line_item(opcode_t op, logic [OFFSET_W-1:0] offset,
                                             logic [LINENUM_W-1:0] line_no);
        item_bytes.delete();
        case (op)
            OP_START: begin
                n_start++;
                push_prog_byte(LNE_ESCAPE, 1'b0);
                push_prog_byte(LNE_SET_ADDR_LN, 1'b0);
                push_prog_byte(LNE_SET_ADDRESS, 1'b0);
                for (int i = 0; i < ADDR_BYTES; i++)
                    push_prog_byte(ZERO_BYTE, i == 0);
                enc_address = offset;
                enc_line    = 1;
            end
            OP_ROW: begin
                n_row++;
                if (line_no != enc_line) begin
                    push_prog_byte(LNS_ADVANCE_LN, 1'b0);
                    push_sleb({{(ULEB_W-LINENUM_W){1'b0}}, line_no}
                              - {{(ULEB_W-LINENUM_W){1'b0}}, enc_line});
                    enc_line = line_no;
                end
                push_pc_advance(offset);
                push_prog_byte(LNS_COPY, 1'b0);
            end
            OP_END: begin
                n_end++;
                push_pc_advance(offset);
                push_prog_byte(LNE_ESCAPE, 1'b0);
                push_prog_byte(LNE_END_LEN, 1'b0);
                push_prog_byte(LNE_END_SEQ, 1'b0);
            end
            default: n_ignored++;
        endcase
        if (item_bytes.size() != 0) begin
            item_bytes[item_bytes.size() - 1].last = 1'b1;
            if (item_bytes.size() > longest_item) longest_item = item_bytes.size();
            foreach (item_bytes[i]) expected_prog_bytes.push_back(item_bytes[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [BYTE_W-1:0] got,
                                   logic [BYTE_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s at byte %0d: got %0h, expected %0h",
                     $realtime, what, bytes_checked, got, want);
    endtask

    // ------------------------------------------------------------------
    // input driver: new transaction at the falling edge once the last is taken
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            if (aresetn && pending_items.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                s_valid       <= 1'b1;
                s_opcode      <= next_item.op;
                s_code_offset <= next_item.offset;
                s_line_number <= next_item.line_no;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver readiness, forced low during a long hold-off
    always @(negedge aclk) begin
        m_ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // long hold-off, counted in cycles here
    always begin
        @(long_hold_go);
        hold_active = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge aclk);
        hold_active = 1'b0;
    end

    // ------------------------------------------------------------------
    // monitor: check output transactions, predict accepted input transactions
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (expected_prog_bytes.size() == 0) begin
                    report_mismatch("byte with nothing expected", m_out_byte, ZERO_BYTE);
                end else begin
                    want_byte = expected_prog_bytes.pop_front();
                    if (m_out_byte !== want_byte.data)
                        report_mismatch("out_byte", m_out_byte, want_byte.data);
                    if (m_reloc_start !== want_byte.reloc)
                        report_mismatch("reloc_start", BYTE_W'(m_reloc_start),
                                        BYTE_W'(want_byte.reloc));
                    if (m_last !== want_byte.last)
                        report_mismatch("last", BYTE_W'(m_last), BYTE_W'(want_byte.last));
                end
                bytes_checked++;
            end
            if (s_valid && s_ready)
                encode_line_item(opcode_t'(s_opcode), s_code_offset, s_line_number);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, expected_prog_bytes.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    function automatic void queue_item(opcode_t op, logic [OFFSET_W-1:0] offset,
                                       logic [LINENUM_W-1:0] line_no);
        line_item_t it;
        it.op      = op;
        it.offset  = offset;
        it.line_no = line_no;
        pending_items.push_back(it);
        if (op != OP_NONE) items_queued++;
    endfunction

    function automatic logic [OFFSET_W-1:0] next_offset(logic [OFFSET_W-1:0] cur);
        case ($urandom_range(0, 9))
            0:       return cur;
            7:       return cur + $urandom_range(128, 20000);
            8:       return $urandom;
            9:       return cur - $urandom_range(1, 300);
            default: return cur + $urandom_range(1, 100);
        endcase
    endfunction

    function automatic logic [LINENUM_W-1:0] next_line(logic [LINENUM_W-1:0] cur);
        case ($urandom_range(0, 9))
            0:       return cur;
            6, 7:    return LINENUM_W'(cur - $urandom_range(1, 20));
            8:       return $urandom_range(0, 1) ? LINENUM_W'(cur + $urandom_range(64, 10000))
                                                 : LINENUM_W'(cur - $urandom_range(64, 10000));
            9:       return LINENUM_W'($urandom_range(0, (1 << LINENUM_W) - 1));
            default: return LINENUM_W'(cur + $urandom_range(1, 20));
        endcase
    endfunction

    // mostly well-formed sequences, with some noise and unterminated ones
    task automatic queue_traffic(int n_items);
        int                   target;
        int                   n_rows;
        logic [OFFSET_W-1:0]  g_addr;
        logic [LINENUM_W-1:0] g_line;
        target = items_queued + n_items;
        while (items_queued < target) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_item(opcode_t'($urandom_range(0, 3)), $urandom,
                           LINENUM_W'($urandom_range(0, (1 << LINENUM_W) - 1)));
            end else begin
                g_addr = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096);
                g_line = 1;
                queue_item(OP_START, g_addr,
                           LINENUM_W'($urandom_range(0, (1 << LINENUM_W) - 1)));
                n_rows = $urandom_range(1, 8);
                repeat (n_rows) begin
                    g_addr = next_offset(g_addr);
                    g_line = next_line(g_line);
                    queue_item(OP_ROW, g_addr, g_line);
                end
                if ($urandom_range(0, 7) != 0)
                    queue_item(OP_END, g_addr + $urandom_range(0, 64),
                               LINENUM_W'($urandom_range(0, (1 << LINENUM_W) - 1)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_prog_bytes.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // directed: state left by reset, extremes of both deltas, ignored opcode
        queue_item(OP_ROW,   32'h0000_0000, 24'd1);
        queue_item(OP_END,   32'h0000_0000, 24'hFFFFFF);
        queue_item(OP_ROW,   32'h0000_0005, 24'd0);
        queue_item(OP_NONE,  32'h1234_5678, 24'h00ABCD);
        queue_item(OP_START, 32'h0000_1000, 24'd77);
        queue_item(OP_ROW,   32'h0000_1000, 24'd1);
        queue_item(OP_ROW,   32'h0000_1001, 24'd2);
        queue_item(OP_ROW,   32'h0000_1081, 24'd65);
        queue_item(OP_ROW,   32'h0000_1082, 24'd129);
        queue_item(OP_ROW,   32'h0000_1083, 24'd65);
        queue_item(OP_ROW,   32'h0000_1084, 24'd0);
        queue_item(OP_ROW,   32'h0000_1085, 24'hFFFFFF);
        queue_item(OP_ROW,   32'h0000_1086, 24'd0);
        queue_item(OP_ROW,   32'h0000_0000, 24'd0);
        queue_item(OP_ROW,   32'hFFFF_FFFF, 24'hFFFFFF);
        queue_item(OP_ROW,   32'h0000_0001, 24'd1);
        queue_item(OP_END,   32'hFFFF_FFFF, 24'd0);
        queue_item(OP_END,   32'hFFFF_FFFF, 24'd0);
        queue_item(OP_START, 32'hFFFF_FFFF, 24'hFFFFFF);
        queue_item(OP_END,   32'h0000_0000, 24'd0);
        queue_item(OP_NONE,  32'hFFFF_FFFF, 24'hFFFFFF);
        queue_item(OP_START, 32'h0000_0000, 24'd0);
        queue_item(OP_ROW,   32'h0000_0000, 24'd0);
        wait_drained();

        // idling phases: none, sender idle, receiver stalling, both
        send_idle_pct = 0;  recv_stall_pct = 0;
        queue_traffic(80);
        wait_drained();
        send_idle_pct = 82; recv_stall_pct = 0;
        queue_traffic(80);
        wait_drained();
        send_idle_pct = 0;  recv_stall_pct = 82;
        queue_traffic(80);
        wait_drained();
        send_idle_pct = 21; recv_stall_pct = 21;
        queue_traffic(80);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;  recv_stall_pct = 0;
        -> long_hold_go;
        queue_traffic(30);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d items: %0d start, %0d row, %0d end, %0d ignored",
                 n_start + n_row + n_end + n_ignored, n_start, n_row, n_end, n_ignored);
        $display("checked %0d program bytes, longest item %0d bytes, %0d mismatches",
                 bytes_checked, longest_item, mismatches);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ltpe_pkg.sv
rtl/core/ltpe_delta.sv
rtl/core/ltpe_emit.sv
rtl/core/line_table_program_encoder_core.sv
tb/tb_top.sv
